### rtl/dca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dca_pkg;

  localparam int NUM_CHANNELS            = 10;
  localparam int SCRATCH_BYTES           = 16384;
  localparam int SECOND_PRIORITY_CHANNEL = 7;
  localparam int WINDOW_BYTES            = 8 * 16;

  localparam int START_W  = 10;
  localparam int ADDR_W   = 31;
  localparam int CH_W     = 4;
  localparam int MASK_W   = 10;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CH_IDX_W = $clog2(NUM_CHANNELS);
  localparam int SCR_W    = $clog2(SCRATCH_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIO_CTRL_EN  = 2'd0,
    CFG_CHAN_EN_MASK  = 2'd1,
    CFG_STALL_DRAIN_EN = 2'd2,
    CFG_STALL_DRAIN_CH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              prio_ctrl_en;
    logic [MASK_W-1:0] chan_en_mask;
    logic              stall_drain_en;
    logic [CH_W-1:0]   stall_drain_ch;
  } cfg_t;

  typedef struct packed {
    logic                    prio_hit;
    logic [CH_W-1:0]         prio_ch;
    logic [NUM_CHANNELS-1:0] elig;
  } class_t;

endpackage
`default_nettype wire

### rtl/dca_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dca_req_if;
  logic                        valid;
  logic                        ready;
  logic [dca_pkg::START_W-1:0] start_bits;
  logic [dca_pkg::ADDR_W-1:0]  drain_address;
  logic                        drain_in_scratchpad;
  logic [dca_pkg::ADDR_W-1:0]  stall_address;

  modport source (
    output valid, start_bits, drain_address, drain_in_scratchpad, stall_address,
    input  ready
  );
  modport sink (
    input  valid, start_bits, drain_address, drain_in_scratchpad, stall_address,
    output ready
  );
endinterface
`default_nettype wire

### rtl/dca_gnt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dca_gnt_if;
  logic                     valid;
  logic                     ready;
  logic                     grant_valid;
  logic [dca_pkg::CH_W-1:0] granted_channel;

  modport source (
    output valid, grant_valid, granted_channel,
    input  ready
  );
  modport sink (
    input  valid, grant_valid, granted_channel,
    output ready
  );
endinterface
`default_nettype wire

### rtl/dca_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dca_front (
  input  wire dca_pkg::cfg_t                cfg_i,
  input  wire logic [dca_pkg::START_W-1:0]  start_bits_i,
  input  wire logic [dca_pkg::ADDR_W-1:0]   drain_address_i,
  input  wire logic                         drain_in_scratchpad_i,
  input  wire logic [dca_pkg::ADDR_W-1:0]   stall_address_i,
  output dca_pkg::class_t                   class_o
);

  logic [dca_pkg::ADDR_W:0]       end_w;
  logic [dca_pkg::ADDR_W-1:0]     end_mod;
  logic                           stalls;

  function automatic logic start_of(input logic [dca_pkg::START_W-1:0] w, input int idx);
    logic r;
    r = 1'b0;
    for (int i = 0; i < dca_pkg::START_W; i++) begin
      if (i == idx) r = w[i];
    end
    return r;
  endfunction

  function automatic logic allowed(input dca_pkg::cfg_t c, input int idx);
    logic r;
    r = 1'b0;
    for (int i = 0; i < dca_pkg::MASK_W; i++) begin
      if (i == idx) r = c.chan_en_mask[i];
    end
    return !c.prio_ctrl_en || r;
  endfunction

  always_comb begin
    end_w   = {1'b0, drain_address_i} + (dca_pkg::ADDR_W + 1)'(dca_pkg::WINDOW_BYTES);
    end_mod = dca_pkg::ADDR_W'(end_w[dca_pkg::SCR_W-1:0]);
    if (!drain_in_scratchpad_i) begin
      stalls = end_w > {1'b0, stall_address_i};
    end else if ({1'b0, stall_address_i} >=
                 (dca_pkg::ADDR_W + 1)'(dca_pkg::SCRATCH_BYTES)) begin
      stalls = 1'b0;
    end else begin
      stalls = ((drain_address_i < stall_address_i) && (end_w > {1'b0, stall_address_i})) ||
               ((drain_address_i >= stall_address_i) && (end_mod > stall_address_i));
    end
  end

  always_comb begin
    class_o = '0;
    if (start_bits_i[0] && allowed(cfg_i, 0)) begin
      class_o.prio_hit = 1'b1;
      class_o.prio_ch  = '0;
    end else if ((dca_pkg::SECOND_PRIORITY_CHANNEL < dca_pkg::NUM_CHANNELS) &&
                 start_of(start_bits_i, dca_pkg::SECOND_PRIORITY_CHANNEL) &&
                 allowed(cfg_i, dca_pkg::SECOND_PRIORITY_CHANNEL)) begin
      class_o.prio_hit = 1'b1;
      class_o.prio_ch  = dca_pkg::CH_W'(dca_pkg::SECOND_PRIORITY_CHANNEL);
    end
    for (int i = 1; i < dca_pkg::NUM_CHANNELS; i++) begin
      class_o.elig[i] = start_of(start_bits_i, i) && allowed(cfg_i, i) &&
                        !(cfg_i.stall_drain_en && (cfg_i.stall_drain_ch == dca_pkg::CH_W'(i)) &&
                          stalls);
    end
  end

endmodule
`default_nettype wire

### rtl/dca_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module dca_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dca_pkg::class_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 nempty_o,
  output dca_pkg::class_t      data_o
);

  dca_pkg::class_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o   = count_q == 2'd2;
  assign nempty_o = count_q != 2'd0;
  assign data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/dca_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dca_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            nempty_i,
  input  wire dca_pkg::class_t data_i,
  output logic                 pop_o,
  dca_gnt_if.source            gnt
);

  logic [dca_pkg::CH_W-1:0] rr_q, rr_d;
  logic                     out_valid_q;
  logic                     grant_valid_q, grant_valid_d;
  logic [dca_pkg::CH_W-1:0] granted_q, granted_d;
  logic [dca_pkg::CH_W:0]   cand;
  logic [dca_pkg::CH_W:0]   step;

  assign pop_o               = nempty_i && (!out_valid_q || gnt.ready);
  assign gnt.valid           = out_valid_q;
  assign gnt.grant_valid     = grant_valid_q;
  assign gnt.granted_channel = granted_q;

  always_comb begin
    step = {1'b0, rr_q} + (dca_pkg::CH_W + 1)'(1);
    if (step >= (dca_pkg::CH_W + 1)'(dca_pkg::NUM_CHANNELS)) begin
      step = (dca_pkg::CH_W + 1)'(1);
    end
    rr_d          = rr_q;
    grant_valid_d = 1'b0;
    granted_d     = '0;
    cand          = '0;
    if (data_i.prio_hit) begin
      grant_valid_d = 1'b1;
      granted_d     = data_i.prio_ch;
    end else begin
      rr_d = step[dca_pkg::CH_W-1:0];
      // Walk from the farthest offset down so the nearest eligible channel wins.
      for (int k = dca_pkg::NUM_CHANNELS - 1; k >= 1; k--) begin
        cand = {1'b0, rr_q} + (dca_pkg::CH_W + 1)'(k);
        if (cand >= (dca_pkg::CH_W + 1)'(dca_pkg::NUM_CHANNELS)) begin
          cand = cand - (dca_pkg::CH_W + 1)'(dca_pkg::NUM_CHANNELS - 1);
        end
        if (data_i.elig[cand[dca_pkg::CH_IDX_W-1:0]]) begin
          grant_valid_d = 1'b1;
          granted_d     = cand[dca_pkg::CH_W-1:0];
          rr_d          = cand[dca_pkg::CH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q        <= dca_pkg::CH_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        rr_q        <= rr_d;
        out_valid_q <= 1'b1;
      end else if (gnt.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grant_valid_q <= grant_valid_d;
      granted_q     <= granted_d;
    end
  end

endmodule
`default_nettype wire

### rtl/dma_channel_arbiter.sv
// Path: a request accepted into the queue is popped by the back end and held in its output register as its result.
// Throughput: one request per cycle while the grant output is not stalled; req.ready falls when the queue is full.
// A two-entry queue between classification and arbitration absorbs output stalls.
// Reset: configuration returns to defaults, the pointer to channel 1, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module dma_channel_arbiter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dca_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dca_pkg::CFG_W-1:0]     cfg_wdata_i,
  dca_req_if.sink                            req,
  dca_gnt_if.source                          gnt
);

  dca_pkg::cfg_t   cfg_q;
  dca_pkg::class_t cls;
  dca_pkg::class_t q_data;
  logic            q_full;
  logic            q_nempty;
  logic            q_pop;
  logic            push;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prio_ctrl_en   <= 1'b0;
      cfg_q.chan_en_mask   <= '0;
      cfg_q.stall_drain_en <= 1'b0;
      cfg_q.stall_drain_ch <= dca_pkg::CH_W'(1);
    end else if (cfg_we_i) begin
      case (dca_pkg::cfg_idx_e'(cfg_idx_i))
        dca_pkg::CFG_PRIO_CTRL_EN:   cfg_q.prio_ctrl_en   <= cfg_wdata_i[0];
        dca_pkg::CFG_CHAN_EN_MASK:   cfg_q.chan_en_mask   <= cfg_wdata_i[dca_pkg::MASK_W-1:0];
        dca_pkg::CFG_STALL_DRAIN_EN: cfg_q.stall_drain_en <= cfg_wdata_i[0];
        dca_pkg::CFG_STALL_DRAIN_CH: cfg_q.stall_drain_ch <= cfg_wdata_i[dca_pkg::CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dca_front u_front (
    .cfg_i                 (cfg_q),
    .start_bits_i          (req.start_bits),
    .drain_address_i       (req.drain_address),
    .drain_in_scratchpad_i (req.drain_in_scratchpad),
    .stall_address_i       (req.stall_address),
    .class_o               (cls)
  );

  dca_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (cls),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .nempty_o (q_nempty),
    .data_o   (q_data)
  );

  dca_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .nempty_i (q_nempty),
    .data_i   (q_data),
    .pop_o    (q_pop),
    .gnt      (gnt)
  );

endmodule
`default_nettype wire

### rtl/dca_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dca_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic                     grant_valid_i,
  input wire logic [dca_pkg::CH_W-1:0] granted_channel_i
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(grant_valid_i) &&
    $stable(granted_channel_i))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && grant_valid_i |->
    granted_channel_i < dca_pkg::CH_W'(dca_pkg::NUM_CHANNELS))
    else $error("granted channel out of range");

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !grant_valid_i |-> granted_channel_i == '0)
    else $error("channel index set without a grant");

  // An empty output fills only from a request that was taken and passed through the queue into the output register.
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a request");

endmodule

bind dma_channel_arbiter dca_checker u_dca_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req.valid),
  .in_ready_i        (req.ready),
  .out_valid_i       (gnt.valid),
  .out_ready_i       (gnt.ready),
  .grant_valid_i     (gnt.grant_valid),
  .granted_channel_i (gnt.granted_channel)
);
`default_nettype wire
